// ===== rtl/tic_pkg.sv =====
// ----------------------------------------------------------------------------
// tic_pkg
// Shared widths and register indexes of the trilinear blend with clamp.
// ----------------------------------------------------------------------------
package tic_pkg;

    localparam int VAL_W      = 32;  // signed Q16.16 corner and result values
    localparam int FRAC_IN_W  = 17;  // fraction port width, one is 2^FRAC_BITS
    localparam int CFG_DATA_W = 17;  // widest configuration register
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANAR_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_VALUE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] FLOOR_RESET = 17'd1;

endpackage

// ===== rtl/tic_lerp.sv =====
// ----------------------------------------------------------------------------
// tic_lerp
// Three-stage linear blend y = a + round((b - a) * f / 2^FRAC_BITS).
// ----------------------------------------------------------------------------
module tic_lerp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic [2:0]                         i_en,
    input  logic signed [tic_pkg::VAL_W-1:0]   i_a,
    input  logic signed [tic_pkg::VAL_W-1:0]   i_b,
    input  logic [FRAC_BITS:0]                 i_frac,
    output logic signed [tic_pkg::VAL_W-1:0]   o_y
);

    localparam int VW = tic_pkg::VAL_W;
    localparam int PW = VW + FRAC_BITS + 3;
    localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));

    logic signed [VW:0]   r_diff;
    logic signed [VW-1:0] r_a1;
    logic [FRAC_BITS:0]   r_f;
    logic signed [PW-1:0] r_prod;
    logic signed [VW-1:0] r_a2;
    logic signed [VW-1:0] r_y;

    logic signed [PW-1:0] w_rnd;
    logic signed [PW-1:0] w_q;

    // a*(S-f) + b*f + S/2, floored by S, equals a + floor(((b-a)*f + S/2) / S).
    // The blend stays between a and b, so the low word is exact.
    assign w_rnd = r_prod + HALF;
    assign w_q   = w_rnd >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_diff <= {i_b[VW-1], i_b} - {i_a[VW-1], i_a};
            r_a1   <= i_a;
            r_f    <= i_frac;
        end
        if (i_en[1]) begin
            r_prod <= r_diff * $signed({1'b0, r_f});
            r_a2   <= r_a1;
        end
        if (i_en[2]) begin
            r_y <= r_a2 + w_q[VW-1:0];
        end
    end

    assign o_y = r_y;

endmodule

// ===== rtl/trilinear_interp_clamp_top.sv =====
// ----------------------------------------------------------------------------
// trilinear_interp_clamp_top
// Trilinear (or planar bilinear) blend of a grid cell with a negative floor.
// ----------------------------------------------------------------------------
// The block takes one cell per cycle when the output side keeps up and returns
// its blend from the output register. The pipeline holds an input register,
// three blend levels (x, then y, then z), each a subtract, a registered multiply
// and a round-and-add stage, and an output register. Every stage stalls on its
// own, so bubbles fill while a result waits. In planar mode the x level runs
// with a zero fraction and passes its corners through.
// Configuration registers are written through a plain write port and must
// only change while no item is in flight.
module trilinear_interp_clamp_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tic_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tic_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_000,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_100,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_110,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_010,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_001,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_101,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_111,
    input  logic signed [tic_pkg::VAL_W-1:0]      i_corner_011,
    input  logic [tic_pkg::FRAC_IN_W-1:0]         i_frac_x,
    input  logic [tic_pkg::FRAC_IN_W-1:0]         i_frac_y,
    input  logic [tic_pkg::FRAC_IN_W-1:0]         i_frac_z,
    input  logic                                  i_clamp_negative,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [tic_pkg::VAL_W-1:0]      o_interp_value,
    output logic                                  o_was_clamped
);

    localparam int VW = tic_pkg::VAL_W;
    localparam int NS = 11;  // input reg, 3 x 3 blend stages, output reg
    localparam int FW = (FRAC_BITS + 1 > tic_pkg::FRAC_IN_W) ? FRAC_BITS + 1
                                                              : tic_pkg::FRAC_IN_W;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    function automatic logic [FRAC_BITS:0] clip_frac(
        input logic [tic_pkg::FRAC_IN_W-1:0] f
    );
        logic [FW-1:0] e;
        e = FW'(f);
        if (e > ONE) begin
            e = ONE;
        end
        return e[FRAC_BITS:0];
    endfunction

    // configuration
    logic                            r_planar;
    logic [tic_pkg::CFG_DATA_W-1:0]  r_floor;

    // stage valids and enables
    logic [NS-1:0] r_v;
    logic [NS:0]   w_en;

    // stage 0 payload
    logic signed [VW-1:0] r_c0 [0:7];
    logic [FRAC_BITS:0]   r_fx0;

    // side data travelling with the blend stages up to where it is used
    logic [FRAC_BITS:0] r_fy_p [0:3];
    logic [FRAC_BITS:0] r_fz_p [0:6];
    logic               r_cl_p [0:9];

    logic signed [VW-1:0] w_x00, w_x10, w_x01, w_x11;
    logic signed [VW-1:0] w_y0, w_y1, w_z;

    logic signed [VW-1:0] r_out;
    logic                 r_clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planar <= 1'b0;
            r_floor  <= tic_pkg::FLOOR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tic_pkg::CFG_PLANAR_MODE) begin
                r_planar <= i_cfg_data[0];
            end else if (i_cfg_idx == tic_pkg::CFG_FLOOR_VALUE) begin
                r_floor <= i_cfg_data;
            end
        end
    end

    // a stage may load when it is empty or its successor loads
    always_comb begin
        w_en[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_c0[0]   <= i_corner_000;
            r_c0[1]   <= i_corner_100;
            r_c0[2]   <= i_corner_110;
            r_c0[3]   <= i_corner_010;
            r_c0[4]   <= i_corner_001;
            r_c0[5]   <= i_corner_101;
            r_c0[6]   <= i_corner_111;
            r_c0[7]   <= i_corner_011;
            // zero x fraction passes the x0 corners through in planar mode
            r_fx0     <= r_planar ? '0 : clip_frac(i_frac_x);
            r_fy_p[0] <= clip_frac(i_frac_y);
            r_fz_p[0] <= clip_frac(i_frac_z);
            r_cl_p[0] <= i_clamp_negative;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_en[k]) begin
                r_fy_p[k] <= r_fy_p[k-1];
            end
        end
        for (int k = 1; k < 7; k++) begin
            if (w_en[k]) begin
                r_fz_p[k] <= r_fz_p[k-1];
            end
        end
        for (int k = 1; k < 10; k++) begin
            if (w_en[k]) begin
                r_cl_p[k] <= r_cl_p[k-1];
            end
        end
    end

    // x level, stages 1 to 3
    tic_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x00 (
        .i_clk(i_clk), .i_en(w_en[3:1]), .i_a(r_c0[0]), .i_b(r_c0[1]),
        .i_frac(r_fx0), .o_y(w_x00)
    );
    tic_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x10 (
        .i_clk(i_clk), .i_en(w_en[3:1]), .i_a(r_c0[3]), .i_b(r_c0[2]),
        .i_frac(r_fx0), .o_y(w_x10)
    );
    tic_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x01 (
        .i_clk(i_clk), .i_en(w_en[3:1]), .i_a(r_c0[4]), .i_b(r_c0[5]),
        .i_frac(r_fx0), .o_y(w_x01)
    );
    tic_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_x11 (
        .i_clk(i_clk), .i_en(w_en[3:1]), .i_a(r_c0[7]), .i_b(r_c0[6]),
        .i_frac(r_fx0), .o_y(w_x11)
    );

    // y level, stages 4 to 6
    tic_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y0 (
        .i_clk(i_clk), .i_en(w_en[6:4]), .i_a(w_x00), .i_b(w_x10),
        .i_frac(r_fy_p[3]), .o_y(w_y0)
    );
    tic_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y1 (
        .i_clk(i_clk), .i_en(w_en[6:4]), .i_a(w_x01), .i_b(w_x11),
        .i_frac(r_fy_p[3]), .o_y(w_y1)
    );

    // z level, stages 7 to 9
    tic_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
        .i_clk(i_clk), .i_en(w_en[9:7]), .i_a(w_y0), .i_b(w_y1),
        .i_frac(r_fz_p[6]), .o_y(w_z)
    );

    // output stage: replace a negative blend with the floor when asked
    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            if (r_cl_p[9] && w_z[VW-1]) begin
                r_out     <= VW'(r_floor);
                r_clamped <= 1'b1;
            end else begin
                r_out     <= w_z;
                r_clamped <= 1'b0;
            end
        end
    end

    assign o_interp_value = r_out;
    assign o_was_clamped  = r_clamped;

endmodule

// ===== rtl/tic_checker.sv =====
// ----------------------------------------------------------------------------
// tic_checker
// Port-level checks of the trilinear blend block, bound to its top level.
// ----------------------------------------------------------------------------
module tic_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_in_ready,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [tic_pkg::VAL_W-1:0]      o_interp_value,
    input  logic                                  o_was_clamped
);

    // a stalled result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_interp_value) && $stable(o_was_clamped))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // the input side never waits when the output side can drain
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output drains");

    // a clamped result is the 17-bit floor, zero extended
    a_clamp_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_clamped |-> o_interp_value[tic_pkg::VAL_W-1:17] == '0)
        else $error("clamped result out of floor range");

endmodule

bind trilinear_interp_clamp_top tic_checker u_tic_checker (.*);

// ===== sim/trilinear_interp_clamp_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_interp_clamp_top_tb
// Self-checking bench for the trilinear blend with negative floor. A short
// table of directed cells runs first. Random cells follow over several
// register settings. Every result is compared with a typed value or a cycle-free
// blend model, and both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module trilinear_interp_clamp_top_tb;

    localparam int     VAL_W        = tic_pkg::VAL_W;
    localparam int     FRAC_IN_W    = tic_pkg::FRAC_IN_W;
    localparam int     CFG_DATA_W   = tic_pkg::CFG_DATA_W;
    localparam int     CFG_IDX_W    = tic_pkg::CFG_IDX_W;
    localparam int     FRAC_BITS    = 16;
    localparam longint FRAC_ONE     = longint'(1) << FRAC_BITS;
    localparam longint FRAC_HALF    = longint'(1) << (FRAC_BITS - 1);
    localparam int     DRAIN_CYCLES = 24;
    localparam int     PHASE_CELLS  = 100;

    typedef logic [7:0][VAL_W-1:0] t_corner_set;  // [0]=000 .. [7]=011, port order

    typedef struct packed {
        t_corner_set          corner;
        logic [FRAC_IN_W-1:0] fx;
        logic [FRAC_IN_W-1:0] fy;
        logic [FRAC_IN_W-1:0] fz;
        logic                 clamp;
    } t_stim;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             clamped;
    } t_blend;

    typedef struct {
        logic                  planar;
        logic [CFG_DATA_W-1:0] floor_v;
        t_stim                 stim;
        bit                    typed;
        t_blend                blend;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [VAL_W-1:0] i_corner_000, i_corner_100, i_corner_110, i_corner_010;
    logic signed [VAL_W-1:0] i_corner_001, i_corner_101, i_corner_111, i_corner_011;
    logic [FRAC_IN_W-1:0] i_frac_x, i_frac_y, i_frac_z;
    logic i_clamp_negative;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [VAL_W-1:0] o_interp_value;
    logic o_was_clamped;

    logic                  cfg_planar;
    logic [CFG_DATA_W-1:0] cfg_floor;

    t_blend   pending_blends[$];
    t_dir_row dir_rows[$];
    int       mismatch_count;
    int       burst_left;
    int       stall_left = 0;
    int       stall_mode = 0;

    trilinear_interp_clamp_top #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_corner_000    (i_corner_000),
        .i_corner_100    (i_corner_100),
        .i_corner_110    (i_corner_110),
        .i_corner_010    (i_corner_010),
        .i_corner_001    (i_corner_001),
        .i_corner_101    (i_corner_101),
        .i_corner_111    (i_corner_111),
        .i_corner_011    (i_corner_011),
        .i_frac_x        (i_frac_x),
        .i_frac_y        (i_frac_y),
        .i_frac_z        (i_frac_z),
        .i_clamp_negative(i_clamp_negative),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_interp_value  (o_interp_value),
        .o_was_clamped   (o_was_clamped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------- blend model
    function automatic longint lerp_round(longint a, longint b, longint f);
        longint acc;
        acc = a * (FRAC_ONE - f) + b * f + FRAC_HALF;
        acc = acc >>> FRAC_BITS;  // floor division
        if (acc > longint'(32'h7FFF_FFFF))
            return longint'(32'h7FFF_FFFF);
        if (acc < -longint'(64'h8000_0000))
            return -longint'(64'h8000_0000);
        return acc;
    endfunction

    function automatic longint frac_limit(logic [FRAC_IN_W-1:0] f);
        return (longint'(f) > FRAC_ONE) ? FRAC_ONE : longint'(f);
    endfunction

    function automatic t_blend predict_blend(t_stim c);
        longint v[8];
        longint fx, fy, fz, r;
        longint x00, x10, x01, x11, y0, y1;
        t_blend res;
        for (int i = 0; i < 8; i++)
            v[i] = longint'($signed(c.corner[i]));
        fx = frac_limit(c.fx);
        fy = frac_limit(c.fy);
        fz = frac_limit(c.fz);
        if (cfg_planar) begin
            y0 = lerp_round(v[0], v[3], fy);
            y1 = lerp_round(v[4], v[7], fy);
        end else begin
            x00 = lerp_round(v[0], v[1], fx);
            x10 = lerp_round(v[3], v[2], fx);
            x01 = lerp_round(v[4], v[5], fx);
            x11 = lerp_round(v[7], v[6], fx);
            y0  = lerp_round(x00, x10, fy);
            y1  = lerp_round(x01, x11, fy);
        end
        r = lerp_round(y0, y1, fz);
        if (c.clamp && r < 0) begin
            res.value   = {{(VAL_W - CFG_DATA_W){1'b0}}, cfg_floor};
            res.clamped = 1'b1;
        end else begin
            res.value   = r[VAL_W-1:0];
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    function automatic t_corner_set same_corners(logic [VAL_W-1:0] v);
        t_corner_set s;
        for (int i = 0; i < 8; i++)
            s[i] = v;
        return s;
    endfunction

    function automatic logic [FRAC_IN_W-1:0] random_frac();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return FRAC_IN_W'($urandom_range(0, 65536));
        else if (pick < 16)
            return '0;
        else if (pick < 18)
            return 17'd65536;
        return FRAC_IN_W'($urandom_range(65537, 131071));  // above one
    endfunction

    function automatic t_stim random_cell();
        t_stim c;
        int style;
        logic [VAL_W-1:0] shared;
        style  = $urandom_range(0, 9);
        shared = $urandom;
        for (int i = 0; i < 8; i++) begin
            case (style)
                0, 1, 2, 3: c.corner[i] = $urandom;
                4, 5, 6, 7: c.corner[i] = VAL_W'(int'($urandom_range(0, 2097152)) - 1048576);
                8: begin
                    case ($urandom_range(0, 3))
                        0:       c.corner[i] = 32'h7FFF_FFFF;
                        1:       c.corner[i] = 32'h8000_0000;
                        2:       c.corner[i] = 32'h0;
                        default: c.corner[i] = 32'hFFFF_FFFF;
                    endcase
                end
                default: c.corner[i] = shared;
            endcase
        end
        c.fx    = random_frac();
        c.fy    = random_frac();
        c.fz    = random_frac();
        c.clamp = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic add_row(input logic planar, input logic [CFG_DATA_W-1:0] floor_v,
                           input t_corner_set cs, input logic [FRAC_IN_W-1:0] fx,
                           input logic [FRAC_IN_W-1:0] fy, input logic [FRAC_IN_W-1:0] fz,
                           input logic clamp, input bit typed,
                           input logic [VAL_W-1:0] value, input logic clamped);
        t_dir_row row;
        row.planar        = planar;
        row.floor_v       = floor_v;
        row.stim.corner   = cs;
        row.stim.fx       = fx;
        row.stim.fy       = fy;
        row.stim.fz       = fz;
        row.stim.clamp    = clamp;
        row.typed         = typed;
        row.blend.value   = value;
        row.blend.clamped = clamped;
        dir_rows.push_back(row);
    endtask

    // ---------------------------------------------------------------- drivers
    task automatic send_cell(input t_stim c, input bit typed, input t_blend typed_blend);
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_corner_000     <= c.corner[0];
        i_corner_100     <= c.corner[1];
        i_corner_110     <= c.corner[2];
        i_corner_010     <= c.corner[3];
        i_corner_001     <= c.corner[4];
        i_corner_101     <= c.corner[5];
        i_corner_111     <= c.corner[6];
        i_corner_011     <= c.corner[7];
        i_frac_x         <= c.fx;
        i_frac_y         <= c.fy;
        i_frac_z         <= c.fz;
        i_clamp_negative <= c.clamp;
        do @(posedge i_clk); while (!o_in_ready);
        pending_blends.push_back(typed ? typed_blend : predict_blend(c));
    endtask

    task automatic pause_input(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // end a burst now and then, with a random gap
    task automatic pace_input();
        burst_left--;
        if (burst_left <= 0) begin
            pause_input($urandom_range(1, 12));
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic wait_drained();
        pause_input(1);
        while (pending_blends.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            tic_pkg::CFG_PLANAR_MODE: cfg_planar = data[0];
            tic_pkg::CFG_FLOOR_VALUE: cfg_floor  = data;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic planar, input logic [CFG_DATA_W-1:0] floor_v);
        wait_drained();
        write_reg(tic_pkg::CFG_PLANAR_MODE, {{(CFG_DATA_W - 1){1'b0}}, planar});
        write_reg(tic_pkg::CFG_FLOOR_VALUE, floor_v);
    endtask

    // ---------------------------------------------------------------- output side
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= int'($urandom_range(0, 2));
            stall_left <= int'($urandom_range(32, 256));
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin : result_check
        t_blend exp_blend;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_blends.size() == 0) begin
                $display("%0t: unexpected result value %h clamped %b",
                         $realtime, o_interp_value, o_was_clamped);
                mismatch_count++;
            end else begin
                exp_blend = pending_blends.pop_front();
                if (o_interp_value !== exp_blend.value) begin
                    $display("%0t: interp_value expected %h actual %h",
                             $realtime, exp_blend.value, o_interp_value);
                    mismatch_count++;
                end
                if (o_was_clamped !== exp_blend.clamped) begin
                    $display("%0t: was_clamped expected %b actual %b",
                             $realtime, exp_blend.clamped, o_was_clamped);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence
    initial begin : main_seq
        t_corner_set mixed;
        t_blend      no_blend;
        logic        phase_planar[7];
        logic [CFG_DATA_W-1:0] phase_floor[7];

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_corner_000     = '0;
        i_corner_100     = '0;
        i_corner_110     = '0;
        i_corner_010     = '0;
        i_corner_001     = '0;
        i_corner_101     = '0;
        i_corner_111     = '0;
        i_corner_011     = '0;
        i_frac_x         = '0;
        i_frac_y         = '0;
        i_frac_z         = '0;
        i_clamp_negative = 1'b0;
        cfg_planar       = 1'b0;
        cfg_floor        = tic_pkg::FLOOR_RESET;
        mismatch_count   = 0;
        burst_left       = $urandom_range(1, 40);
        no_blend         = '0;

        mixed[0] = 32'h0001_0000;
        mixed[1] = 32'h7FFF_FFFF;
        mixed[2] = 32'h8000_0000;
        mixed[3] = 32'hFFFF_0000;
        mixed[4] = 32'h1234_5678;
        mixed[5] = 32'hEDCB_A988;
        mixed[6] = 32'h5555_5555;
        mixed[7] = 32'hAAAA_AAAA;

        // reset settings first; zero results stay unclamped
        add_row(1'b0, 17'd1, same_corners(32'h0), 17'h08000, 17'h08000, 17'h08000, 1'b1,
                1'b1, 32'h0, 1'b0);
        add_row(1'b0, 17'd1, same_corners(32'h7FFF_FFFF), 17'h04000, 17'h08000, 17'h0C000,
                1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0);
        add_row(1'b0, 17'd1, same_corners(32'h8000_0000), 17'h0FFFF, 17'h00001, 17'h0ABCD,
                1'b0, 1'b1, 32'h8000_0000, 1'b0);
        add_row(1'b0, 17'd1, same_corners(32'h8000_0000), 17'h0FFFF, 17'h00001, 17'h0ABCD,
                1'b1, 1'b1, 32'h1, 1'b1);
        add_row(1'b0, 17'd1, mixed, 17'h0, 17'h0, 17'h0, 1'b0, 1'b1, 32'h0001_0000, 1'b0);
        add_row(1'b0, 17'd1, mixed, 17'h10000, 17'h10000, 17'h10000, 1'b1,
                1'b1, 32'h5555_5555, 1'b0);
        // fractions above one act as exactly one
        add_row(1'b0, 17'd1, mixed, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b0,
                1'b1, 32'h5555_5555, 1'b0);
        add_row(1'b0, 17'd1, mixed, 17'h1FFFF, 17'h0, 17'h0, 1'b0,
                1'b1, 32'h7FFF_FFFF, 1'b0);
        add_row(1'b0, 17'd1, mixed, 17'h01234, 17'h0ABCD, 17'h10000, 1'b1,
                1'b0, 32'h0, 1'b0);
        add_row(1'b0, 17'd1, same_corners(32'hFFFF_FFFF), 17'h08000, 17'h0, 17'h1FFFF, 1'b1,
                1'b1, 32'h1, 1'b1);
        // planar: frac_x has no effect
        add_row(1'b1, 17'd1, mixed, 17'h10000, 17'h0, 17'h0, 1'b0,
                1'b1, 32'h0001_0000, 1'b0);
        add_row(1'b1, 17'd1, mixed, 17'h1FFFF, 17'h10000, 17'h10000, 1'b0,
                1'b1, 32'hAAAA_AAAA, 1'b0);
        add_row(1'b1, 17'd1, mixed, 17'h0, 17'h0, 17'h10000, 1'b1,
                1'b1, 32'h1234_5678, 1'b0);
        add_row(1'b1, 17'd1, mixed, 17'h0FFFF, 17'h08000, 17'h03000, 1'b1,
                1'b0, 32'h0, 1'b0);
        // floor of zero and above one pass through as written
        add_row(1'b1, 17'd0, same_corners(32'h8000_0000), 17'h0, 17'h08000, 17'h08000, 1'b1,
                1'b1, 32'h0, 1'b1);
        add_row(1'b0, 17'h10000, same_corners(32'hFFFF_0000), 17'h1, 17'h2, 17'h3, 1'b1,
                1'b1, 32'h0001_0000, 1'b1);
        add_row(1'b0, 17'h1FFFF, mixed, 17'h0, 17'h10000, 17'h0, 1'b1,
                1'b1, 32'h0001_FFFF, 1'b1);
        add_row(1'b0, 17'h1FFFF, mixed, 17'h0C001, 17'h03FFF, 17'h07777, 1'b1,
                1'b0, 32'h0, 1'b0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].planar !== cfg_planar || dir_rows[r].floor_v !== cfg_floor)
                set_config(dir_rows[r].planar, dir_rows[r].floor_v);
            send_cell(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].blend);
            pace_input();
        end

        phase_planar = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_floor  = '{17'd1, 17'd1, 17'd0, 17'd65536, 17'h1FFFF,
                         17'($urandom_range(1, 65536)), 17'($urandom_range(1, 65536))};
        for (int p = 0; p < 7; p++) begin
            set_config(phase_planar[p], phase_floor[p]);
            for (int n = 0; n < PHASE_CELLS; n++) begin
                // hold off once until the pipe runs dry
                if (p == 2 && n == PHASE_CELLS / 2)
                    wait_drained();
                send_cell(random_cell(), 1'b0, no_blend);
                pace_input();
            end
        end

        wait_drained();
        if (mismatch_count == 0 && pending_blends.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
